// ===== rtl/mi3_pkg.sv =====
// Shared constants and types of the 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int ELEM_W     = 32;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int COF_W      = PROD_W + 1;
   localparam int DET_W      = COF_W + ELEM_W + 2;
   localparam int SHIFT      = 2 * FRAC_BITS;
   localparam int NUM_W      = COF_W + SHIFT;
   localparam int QB         = ELEM_W + 1;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = QPTR_W + 1;
   localparam int NELEM      = 9;
   localparam int ELEM_IDX_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] SIZE_2X2   = 2'd2;
   localparam logic [1:0] SIZE_RESET = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SIZE = '0;

   // One classified matrix: adjugate entries (row-major) and determinant.
   typedef struct packed {
      logic [NELEM-1:0][COF_W-1:0] adj;
      logic [DET_W-1:0]            det;
   } job_type;
endpackage
`default_nettype wire

// ===== rtl/matrix_inverse_3x3.sv =====
// Top level of the 2x2 / 3x3 fixed-point matrix inverse.
// A word passes three front stages, a queue write, a pick-up by the back end, nine
// quotients (each a load plus 33 divider steps), an emit and the result register.
// A singular matrix skips the quotients. The shared bit-serial divider takes one word at
// a time while the queue holds later ones; four words go in back to back.
// Results cannot be held off. Synchronous reset empties the pipeline and queue, size 3.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m00,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m01,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m02,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m10,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m11,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m12,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m20,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m21,
   input  wire logic [mi3_pkg::ELEM_W-1:0]        req_m22,
   output logic                                   rsp_done,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv00,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv01,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv02,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv10,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv11,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv12,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv20,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv21,
   output logic [mi3_pkg::ELEM_W-1:0]             rsp_inv22,
   output logic                                   rsp_singular,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [mi3_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [mi3_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mi3_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import mi3_pkg::*;

   logic [1:0]                    size_ff;
   logic                          accept;
   logic [2:0]                    stage_valid;
   logic                          push, pop, not_empty;
   job_type                       push_job, head_job;
   logic [QCNT_W-1:0]             count;
   logic [QCNT_W:0]               reserved;
   logic [NELEM-1:0][ELEM_W-1:0]  m, inv;

   // Size register; codes other than 2 run the full 3x3 path.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (psel && penable && pwrite && pready && (paddr == ADDR_SIZE)) begin
         size_ff <= pwdata[1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   // A word is taken only when a queue slot is sure to be free for it
   // once it leaves the front pipeline, so the front end never stalls.
   assign reserved = (QCNT_W+1)'(count) + (QCNT_W+1)'(stage_valid[0])
                   + (QCNT_W+1)'(stage_valid[1]) + (QCNT_W+1)'(stage_valid[2]);
   assign busy     = reserved >= (QCNT_W+1)'(QDEPTH);
   assign accept   = start && !busy;

   assign m = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
               req_m02, req_m01, req_m00};

   mi3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .two_by_two  (size_ff == SIZE_2X2),
      .m           (m),
      .stage_valid (stage_valid),
      .push        (push),
      .job         (push_job)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .count     (count)
   );

   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (not_empty),
      .job       (head_job),
      .pop       (pop),
      .done      (rsp_done),
      .singular  (rsp_singular),
      .inv       (inv)
   );

   assign rsp_inv00 = inv[0];
   assign rsp_inv01 = inv[1];
   assign rsp_inv02 = inv[2];
   assign rsp_inv10 = inv[3];
   assign rsp_inv11 = inv[4];
   assign rsp_inv12 = inv[5];
   assign rsp_inv20 = inv[6];
   assign rsp_inv21 = inv[7];
   assign rsp_inv22 = inv[8];

   // The queue never holds more words than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count <= QCNT_W'(QDEPTH))
      else $error("job queue overfilled");

   // A word reaching the queue was reserved while it was in flight.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (reserved <= (QCNT_W+1)'(QDEPTH)))
      else $error("push without a free slot");

   // A singular result carries all-zero elements.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_singular) |-> (inv == '0))
      else $error("singular result with nonzero elements");
endmodule
`default_nettype wire

// ===== rtl/mi3_front.sv =====
// Front end: cofactors, adjugate and determinant in three pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module mi3_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   input  wire logic                                    two_by_two,
   input  wire logic [mi3_pkg::NELEM-1:0][mi3_pkg::ELEM_W-1:0] m,
   output logic [2:0]                                   stage_valid,
   output logic                                         push,
   output mi3_pkg::job_type                             job
);
   import mi3_pkg::*;

   logic                              v1_ff, v2_ff, v3_ff;
   logic                              two1_ff, two2_ff;
   logic [NELEM-1:0][COF_W-1:0]       cof_in, cof1_ff;
   logic [2:0][ELEM_W-1:0]            row0_ff;
   logic [ELEM_W-1:0]                 m_hold11_ff, m_hold01_ff, m_hold10_ff;
   logic [NELEM-1:0][COF_W-1:0]       adj_in, adj2_ff;
   logic [2:0][PROD_W+1:0]            plo_in, plo_ff;
   logic [2:0][PROD_W-1:0]            phi_in, phi_ff;
   logic [COF_W-1:0]                  det2_ff;
   job_type                           job_in, job_ff;

   // Stage 1: each cofactor is the difference of two 32x32 products.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         logic signed [PROD_W-1:0] pa, pb;
         assign pa = $signed(m[I1*3+J1]) * $signed(m[I2*3+J2]);
         assign pb = $signed(m[I1*3+J2]) * $signed(m[I2*3+J1]);
         assign cof_in[i*3+j] = COF_W'($signed(pa)) - COF_W'($signed(pb));
      end
   end

   // Stage 2: adjugate selection and split partial products of row 0.
   always_comb begin
      adj_in = '0;
      if (two1_ff) begin
         adj_in[0] = COF_W'($signed(m_hold11_ff));
         adj_in[1] = -COF_W'($signed(m_hold01_ff));
         adj_in[3] = -COF_W'($signed(m_hold10_ff));
         adj_in[4] = COF_W'($signed(row0_ff[0]));
      end else begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               adj_in[i*3+j] = cof1_ff[j*3+i];
            end
         end
      end
      for (int j = 0; j < 3; j++) begin
         plo_in[j] = (PROD_W+2)'($signed({1'b0, cof1_ff[j][QB-1:0]}) *
                                 $signed(row0_ff[j]));
         phi_in[j] = $signed(cof1_ff[j][COF_W-1:QB]) * $signed(row0_ff[j]);
      end
   end

   // Stage 3: determinant sum; in 2x2 mode it is the lower-right cofactor.
   always_comb begin
      job_in.adj = adj2_ff;
      if (two2_ff) begin
         job_in.det = DET_W'($signed(det2_ff));
      end else begin
         job_in.det = '0;
         for (int j = 0; j < 3; j++) begin
            job_in.det = job_in.det + (DET_W'($signed(phi_ff[j])) <<< QB)
                         + DET_W'($signed(plo_ff[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      cof1_ff     <= cof_in;
      row0_ff     <= {m[2], m[1], m[0]};
      m_hold11_ff <= m[4];
      m_hold01_ff <= m[1];
      m_hold10_ff <= m[3];
      two1_ff     <= two_by_two;
      two2_ff     <= two1_ff;
      adj2_ff     <= adj_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      det2_ff     <= cof1_ff[8];
      job_ff      <= job_in;
   end

   assign stage_valid = {v3_ff, v2_ff, v1_ff};
   assign push        = v3_ff;
   assign job         = job_ff;
endmodule
`default_nettype wire

// ===== rtl/mi3_queue.sv =====
// Short job queue between the front end and the divider back end.
`timescale 1ns / 1ps
`default_nettype none
module mi3_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire mi3_pkg::job_type         push_job,
   input  wire logic                     pop,
   output mi3_pkg::job_type              head_job,
   output logic                          not_empty,
   output logic [mi3_pkg::QCNT_W-1:0]    count
);
   import mi3_pkg::*;

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
      end
      if (push) slot_ff[wr_ff] <= push_job;
   end

   assign head_job  = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;
endmodule
`default_nettype wire

// ===== rtl/mi3_back.sv =====
// Back end: one restoring divider that forms all nine saturated quotients.
`timescale 1ns / 1ps
`default_nettype none
module mi3_back (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     job_ready,
   input  wire mi3_pkg::job_type                         job,
   output logic                                          pop,
   output logic                                          done,
   output logic                                          singular,
   output logic [mi3_pkg::NELEM-1:0][mi3_pkg::ELEM_W-1:0] inv
);
   import mi3_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_EMIT} state_type;

   localparam int CNT_W  = $clog2(QB);

   state_type                      state_ff;
   job_type                        job_ff;
   logic [DET_W-1:0]               dmag_ff;
   logic                           dneg_ff;
   logic [ELEM_IDX_W-1:0]          elem_ff;
   logic [DET_W-1:0]               rem_ff;
   logic [QB-1:0]                  numlo_ff, q_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           neg_ff, ovf_ff;
   logic                           done_ff, sing_ff;
   logic [NELEM-1:0][ELEM_W-1:0]   inv_ff;

   logic [COF_W-1:0]  cur_cof, cof_mag;
   logic [NUM_W-1:0]  num;
   logic [DET_W:0]    rem_sh;
   logic              ge;
   logic [QB-1:0]     q_last;
   logic [ELEM_W-1:0] quo;
   logic [DET_W-1:0]  det_mag;

   always_comb begin
      cur_cof = job_ff.adj[elem_ff];
      cof_mag = cur_cof[COF_W-1] ? (~cur_cof + 1'b1) : cur_cof;
      num     = {cof_mag, {SHIFT{1'b0}}};
      det_mag = job.det[DET_W-1] ? (~job.det + 1'b1) : job.det;
      rem_sh  = {rem_ff, numlo_ff[QB-1]};
      ge      = rem_sh >= {1'b0, dmag_ff};
      q_last  = {q_ff[QB-2:0], ge};
      // Round toward zero, then clamp to the signed 32-bit range.
      if (neg_ff) begin
         if (ovf_ff || (q_last > QB'(33'h0_8000_0000))) begin
            quo = {1'b1, {(ELEM_W-1){1'b0}}};
         end else begin
            quo = ELEM_W'(~q_last + 1'b1);
         end
      end else begin
         if (ovf_ff || (q_last > QB'(33'h0_7FFF_FFFF))) begin
            quo = {1'b0, {(ELEM_W-1){1'b1}}};
         end else begin
            quo = q_last[ELEM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         sing_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_ready) begin
                  job_ff  <= job;
                  dmag_ff <= det_mag;
                  dneg_ff <= job.det[DET_W-1];
                  elem_ff <= '0;
                  if (job.det == '0) begin
                     inv_ff   <= '0;
                     sing_ff  <= 1'b1;
                     state_ff <= ST_EMIT;
                  end else begin
                     sing_ff  <= 1'b0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               rem_ff   <= DET_W'(num[NUM_W-1:QB]);
               numlo_ff <= num[QB-1:0];
               ovf_ff   <= DET_W'(num[NUM_W-1:QB]) >= dmag_ff;
               neg_ff   <= cur_cof[COF_W-1] ^ dneg_ff;
               q_ff     <= '0;
               cnt_ff   <= CNT_W'(QB - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= ge ? DET_W'(rem_sh - {1'b0, dmag_ff}) : DET_W'(rem_sh);
               numlo_ff <= {numlo_ff[QB-2:0], 1'b0};
               q_ff     <= q_last;
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  inv_ff[elem_ff] <= quo;
                  if (elem_ff == ELEM_IDX_W'(NELEM - 1)) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     elem_ff  <= elem_ff + 1'b1;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_EMIT: begin
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign pop      = (state_ff == ST_IDLE) && job_ready;
   assign done     = done_ff;
   assign singular = sing_ff;
   assign inv      = inv_ff;
endmodule
`default_nettype wire

// ===== tb/matrix_inverse_3x3_test.sv =====
// Self-checking testbench for the 2x2 / 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   // Nine matrix elements, row-major, index 0 is row 0 column 0.
   typedef logic [0:NELEM-1][ELEM_W-1:0] matrix_type;

   // One inverse word as the block should deliver it.
   typedef struct {
      matrix_type inv;
      logic       singular;
   } inverse_type;

   // A row of the directed stimulus table.
   typedef struct {
      logic [1:0]  size;
      matrix_type  elems;
      bit          typed;
      inverse_type answer;
   } directed_row_type;

   localparam logic [ELEM_W-1:0] ONE     = 32'h0001_0000;
   localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
   localparam int RANDOM_PER_PHASE = 190;
   localparam int STALL_LIMIT      = 20000;
   localparam int TAIL_CYCLES      = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ELEM_W-1:0]     req_elem [NELEM];
   logic                  rsp_done;
   logic [ELEM_W-1:0]     rsp_elem [NELEM];
   logic                  rsp_singular;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   inverse_type      pending_inverses [$];
   directed_row_type directed_rows [$];
   logic [1:0]       size_shadow = SIZE_RESET;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   bit               calm_stretch = 1'b0;

   initial begin
      for (int k = 0; k < NELEM; k++) req_elem[k] = '0;
   end

   initial begin
      forever #1 clock = ~clock;
   end

   matrix_inverse_3x3 i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(req_elem[0]), .req_m01(req_elem[1]), .req_m02(req_elem[2]),
      .req_m10(req_elem[3]), .req_m11(req_elem[4]), .req_m12(req_elem[5]),
      .req_m20(req_elem[6]), .req_m21(req_elem[7]), .req_m22(req_elem[8]),
      .rsp_done(rsp_done),
      .rsp_inv00(rsp_elem[0]), .rsp_inv01(rsp_elem[1]), .rsp_inv02(rsp_elem[2]),
      .rsp_inv10(rsp_elem[3]), .rsp_inv11(rsp_elem[4]), .rsp_inv12(rsp_elem[5]),
      .rsp_inv20(rsp_elem[6]), .rsp_inv21(rsp_elem[7]), .rsp_inv22(rsp_elem[8]),
      .rsp_singular(rsp_singular),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Exact inverse by the adjugate. The products, the determinant and the
   // shifted cofactor all fit comfortably in 160 signed bits, so the quotient
   // is exact and truncates toward zero as the block's divider does.
   function automatic inverse_type invert_matrix(matrix_type m, logic [1:0] size);
      logic signed [159:0] a [NELEM];
      logic signed [159:0] cof [NELEM];
      logic signed [159:0] det;
      logic signed [159:0] quo;
      inverse_type         r;
      int                  n;
      int                  i1, i2, j1, j2;
      for (int k = 0; k < NELEM; k++) begin
         a[k]   = $signed(m[k]);
         cof[k] = '0;
      end
      det = '0;
      if (size == SIZE_2X2) begin
         n      = 2;
         cof[0] = a[4];
         cof[1] = -a[3];
         cof[3] = -a[1];
         cof[4] = a[0];
         det    = a[0] * a[4] - a[1] * a[3];
      end else begin
         // Size codes 0 and 1 fall back to the full 3x3 matrix.
         n = 3;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               i1 = (i + 1) % 3;
               i2 = (i + 2) % 3;
               j1 = (j + 1) % 3;
               j2 = (j + 2) % 3;
               cof[i*3+j] = a[i1*3+j1] * a[i2*3+j2] - a[i1*3+j2] * a[i2*3+j1];
            end
         end
         for (int j = 0; j < 3; j++) det = det + cof[j] * a[j];
      end
      r.inv      = '0;
      r.singular = (det == 0);
      if (!r.singular) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               // The adjugate is the transposed cofactor matrix.
               quo = (cof[j*3+i] <<< SHIFT) / det;
               if (quo > 160'sh7FFF_FFFF)
                  r.inv[i*3+j] = ELEM_MAX;
               else if (quo < -160'sh8000_0000)
                  r.inv[i*3+j] = ELEM_MIN;
               else
                  r.inv[i*3+j] = quo[ELEM_W-1:0];
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [ELEM_W-1:0] got,
                                  logic [ELEM_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // Every strobed result is matched against the oldest outstanding inverse.
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_done) begin
         if (pending_inverses.size() == 0) begin
            $display("MISMATCH: result word with nothing outstanding at %0t", $realtime);
            mismatch_count++;
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k < NELEM; k++) begin
               if (rsp_elem[k] !== want.inv[k])
                  report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                  rsp_elem[k], want.inv[k]);
            end
            if (rsp_singular !== want.singular)
               report_mismatch("singular", ELEM_W'(rsp_singular), ELEM_W'(want.singular));
         end
      end
   end

   // The watchdog measures cycles in which neither a matrix nor a result moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_done)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Two-phase register write; the block takes it at the end of the access cycle.
   task automatic write_size(logic [1:0] size);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_SIZE;
      pwdata  <= CSR_DATA_W'(size);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      size_shadow  = size;
   endtask

   // The size may only change once every outstanding word has come back.
   task automatic drain_and_resize(logic [1:0] size);
      start <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_size(size);
   endtask

   // Present one matrix and hold it until the block takes it. Start is left
   // high so that a following word can go out back to back.
   task automatic send_matrix(matrix_type m, bit typed, inverse_type answer);
      for (int k = 0; k < NELEM; k++) req_elem[k] <= m[k];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_inverses.push_back(typed ? answer : invert_matrix(m, size_shadow));
      if (!calm_stretch && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic logic [ELEM_W-1:0] pick_extreme();
      case ($urandom_range(0, 6))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return 32'd1;
         4: return 32'hFFFF_FFFF;
         5: return ONE;
         default: return $urandom;
      endcase
   endfunction

   // Random matrices: small well-conditioned values most often, plus raw noise,
   // deliberately singular matrices, extremes and tiny values that saturate.
   function automatic matrix_type random_matrix();
      matrix_type m;
      int         flavor;
      flavor = $urandom_range(0, 99);
      for (int k = 0; k < NELEM; k++) begin
         if (flavor < 40)
            m[k] = $urandom_range(0, 8 << FRAC_BITS) - (4 << FRAC_BITS);
         else if (flavor < 55)
            m[k] = $urandom;
         else if (flavor < 70)
            m[k] = $urandom_range(0, 6 << FRAC_BITS) - (3 << FRAC_BITS);
         else if (flavor < 85)
            m[k] = pick_extreme();
         else
            m[k] = $urandom_range(0, 64) - 32;
      end
      // Copying row 0 into row 1 makes both the 2x2 and the 3x3 case singular.
      if (flavor >= 55 && flavor < 70)
         for (int j = 0; j < 3; j++) m[3+j] = m[j];
      return m;
   endfunction

   task automatic add_row(logic [1:0] size, matrix_type elems, bit typed,
                          matrix_type inv, logic singular);
      directed_row_type row;
      row.size            = size;
      row.elems           = elems;
      row.typed           = typed;
      row.answer.inv      = inv;
      row.answer.singular = singular;
      directed_rows.push_back(row);
   endtask

   initial begin
      logic [1:0]  phase_sizes [5];
      inverse_type unused;
      phase_sizes = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd3};
      unused.inv      = '0;
      unused.singular = 1'b0;

      // Identity, zero and the field extremes in full size first.
      add_row(2'd3, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE},
              1'b1, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE}, 1'b0);
      add_row(2'd3, '0, 1'b1, '0, 1'b1);
      add_row(2'd3, {NELEM{ELEM_MAX}}, 1'b1, '0, 1'b1);
      add_row(2'd3, {NELEM{ELEM_MIN}}, 1'b1, '0, 1'b1);
      add_row(2'd3, {32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1},
              1'b0, '0, 1'b0);
      add_row(2'd3, {ELEM_MIN, 32'd0, 32'd0, 32'd0, ELEM_MAX, 32'd0, 32'd0, 32'd0, ELEM_MIN},
              1'b0, '0, 1'b0);
      add_row(2'd3, {32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'h0002_0000, 32'd0,
                     32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, '0, 1'b0);
      add_row(2'd3, {ELEM_MAX, ELEM_MIN, 32'd5, 32'd7, ELEM_MAX, ELEM_MIN,
                     ELEM_MIN, 32'd3, ELEM_MAX}, 1'b0, '0, 1'b0);
      add_row(2'd3, {ONE, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 32'hFFFF_0000,
                     32'h0004_0000, 32'h0001_8000, 32'h0005_0000, 32'hFFFE_0000},
              1'b0, '0, 1'b0);
      // In 2x2 mode the right column and bottom row are ignored and read as zero.
      add_row(2'd2, {ONE, 32'd0, ELEM_MAX, 32'd0, ONE, ELEM_MIN, ELEM_MAX, ELEM_MIN, 32'd9},
              1'b1, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b0);
      add_row(2'd2, {32'd0, 32'd0, ONE, 32'd0, 32'd0, ONE, ONE, ONE, ONE}, 1'b1, '0, 1'b1);
      add_row(2'd2, {ELEM_MIN, ELEM_MAX, 32'd1, ELEM_MAX, ELEM_MIN, 32'd2, 32'd3, 32'd4,
                     32'd5}, 1'b0, '0, 1'b0);
      add_row(2'd2, {32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                     32'd0}, 1'b0, '0, 1'b0);
      add_row(2'd2, {32'h0003_0000, ONE, 32'd0, 32'h0002_0000, 32'h0005_0000, 32'd0,
                     32'd0, 32'd0, 32'd0}, 1'b0, '0, 1'b0);
      // Size codes 0 and 1 behave as the full 3x3 case.
      add_row(2'd0, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE},
              1'b1, {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE}, 1'b0);
      add_row(2'd0, {32'h0002_0000, 32'd1, 32'd0, 32'd0, 32'h0002_0000, 32'd0,
                     32'd0, 32'd0, 32'h0004_0000}, 1'b0, '0, 1'b0);
      add_row(2'd1, {32'd0, 32'd0, 32'd0, ONE, ONE, ONE, 32'd7, 32'd8, 32'd9},
              1'b1, '0, 1'b1);
      add_row(2'd1, {ELEM_MAX, 32'd1, 32'd2, 32'd3, ELEM_MAX, 32'd4, 32'd5, 32'd6,
                     ELEM_MAX}, 1'b0, '0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].size != size_shadow)
            drain_and_resize(directed_rows[r].size);
         send_matrix(directed_rows[r].elems, directed_rows[r].typed,
                     directed_rows[r].answer);
      end

      // Random words in several size phases; the middle of the second phase
      // runs with no idling at all so that the queue inside the block fills.
      foreach (phase_sizes[p]) begin
         drain_and_resize(phase_sizes[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            calm_stretch = (p == 1) && (n >= 40) && (n < 140);
            send_matrix(random_matrix(), 1'b0, unused);
         end
      end

      start <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
